[src/pse_pkg.sv]
// Package for the plot stream frame extractor.
// Holds widths, command decode types and the command letter table.
// No dependencies.
package pse_pkg;

  // Widths fixed by the stream format and the configuration register
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WANTED_W       = 16;
  localparam int unsigned ARG_W          = 6;
  localparam int unsigned FRAME_BITS_DEF = 16;

  // Newline that closes a label argument
  localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;

  // Class of a command byte
  typedef enum logic [1:0] {
    CMD_BAD,
    CMD_ARG,
    CMD_LABEL,
    CMD_ERASE
  } cmd_kind_e;

  // Decoded command: class and fixed argument length
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ARG_W-1:0] arg_len;
  } cmd_dec_t;

  // Look up a command letter in the fixed command table
  function automatic cmd_dec_t cmd_lookup(input logic [BYTE_W-1:0] b);
    cmd_dec_t d;
    d.kind    = CMD_ARG;
    d.arg_len = '0;
    unique case (b)
      "C": d.arg_len = ARG_W'(3);
      "F": d.arg_len = ARG_W'(0);
      "L": d.arg_len = ARG_W'(12);
      "M": d.arg_len = ARG_W'(6);
      "N": d.arg_len = ARG_W'(6);
      "O": d.arg_len = ARG_W'(24);
      "P": d.arg_len = ARG_W'(6);
      "Q": d.arg_len = ARG_W'(24);
      "S": d.arg_len = ARG_W'(12);
      "V": d.arg_len = ARG_W'(48);
      "W": d.arg_len = ARG_W'(48);
      "X": d.arg_len = ARG_W'(24);
      "a": d.arg_len = ARG_W'(12);
      "c": d.arg_len = ARG_W'(6);
      "e": d.kind    = CMD_ERASE;
      "f": d.kind    = CMD_LABEL;
      "i": d.arg_len = ARG_W'(24);
      "l": d.arg_len = ARG_W'(8);
      "m": d.arg_len = ARG_W'(4);
      "n": d.arg_len = ARG_W'(4);
      "o": d.arg_len = ARG_W'(16);
      "p": d.arg_len = ARG_W'(4);
      "q": d.arg_len = ARG_W'(16);
      "r": d.arg_len = ARG_W'(48);
      "s": d.arg_len = ARG_W'(8);
      "t": d.kind    = CMD_LABEL;
      "v": d.arg_len = ARG_W'(32);
      "w": d.arg_len = ARG_W'(32);
      "x": d.arg_len = ARG_W'(16);
      default: d.kind = CMD_BAD;
    endcase
    return d;
  endfunction

endpackage

[src/pse_if.sv]
// Valid/ready stream interfaces for the plot stream frame extractor.
// Depends on pse_pkg for the byte width.
interface pse_in_if import pse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

[src/pse_cmd_decode.sv]
// Command byte decoder: maps a byte to its command class and argument length.
// Depends on pse_pkg for the command table.
module pse_cmd_decode import pse_pkg::*; (
  input  logic [BYTE_W-1:0] byte_i,
  output cmd_dec_t          dec_o
);

  // Decode through the fixed letter table
  always_comb begin
    dec_o = cmd_lookup(byte_i);
  end

endmodule

[src/pse_frame_ctrl.sv]
// Frame tracking state: argument skipping, label tracking and frame counter.
// Decides whether each consumed byte is passed on. Depends on pse_pkg.
module pse_frame_ctrl import pse_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [BYTE_W-1:0]   byte_i,
  input  cmd_dec_t            dec_i,
  input  logic [WANTED_W-1:0] wanted_frame_i,
  output logic                emit_o
);

  // Common width for comparing the counter with the wanted frame
  localparam int unsigned CMP_W = (FRAME_BITS > WANTED_W) ? FRAME_BITS : WANTED_W;

  logic [FRAME_BITS-1:0] frame_index_q, frame_index_d;
  logic                  finished_q, finished_d;
  logic [ARG_W-1:0]      arg_left_q, arg_left_d;
  logic                  in_label_q, in_label_d;

  logic [CMP_W:0]        wanted_ext;
  logic [CMP_W:0]        index_ext;
  logic [CMP_W:0]        next_ext;
  logic                  match;
  logic                  at_max;

  // Widen both sides of the frame comparisons
  assign wanted_ext = (CMP_W + 1)'(wanted_frame_i);
  assign index_ext  = (CMP_W + 1)'(frame_index_q);
  assign next_ext   = index_ext + (CMP_W + 1)'(1);
  assign match      = (index_ext == wanted_ext);
  assign at_max     = &frame_index_q;

  // Next state and pass decision for the byte being consumed
  always_comb begin
    frame_index_d = frame_index_q;
    finished_d    = finished_q;
    arg_left_d    = arg_left_q;
    in_label_d    = in_label_q;
    emit_o        = 1'b0;
    priority if (finished_q) begin
      emit_o = 1'b0;
    end else if (in_label_q) begin
      if (byte_i == LF_CODE) begin
        in_label_d = 1'b0;
      end
      emit_o = match;
    end else if (arg_left_q != '0) begin
      arg_left_d = arg_left_q - ARG_W'(1);
      emit_o     = match;
    end else begin
      unique case (dec_i.kind)
        CMD_ERASE: begin
          if (next_ext > wanted_ext) begin
            finished_d = 1'b1;
          end
          // Saturate the counter at its top value
          if (!at_max) begin
            frame_index_d = frame_index_q + FRAME_BITS'(1);
          end
        end
        CMD_LABEL: begin
          in_label_d = 1'b1;
          emit_o     = match;
        end
        CMD_ARG: begin
          arg_left_d = dec_i.arg_len;
          emit_o     = match;
        end
        CMD_BAD: begin
          emit_o = 1'b0;
        end
        default: begin
          emit_o = 1'b0;
        end
      endcase
    end
  end

  // Update state only when a byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_index_q <= '0;
      finished_q    <= 1'b0;
      arg_left_q    <= '0;
      in_label_q    <= 1'b0;
    end else if (step_i) begin
      frame_index_q <= frame_index_d;
      finished_q    <= finished_d;
      arg_left_q    <= arg_left_d;
      in_label_q    <= in_label_d;
    end
  end

endmodule

[src/plot_stream_frame_extractor.sv]
// Plot stream frame extractor: input register, decode and state, result register.
// Depends on pse_pkg, pse_in_if, pse_out_if, pse_cmd_decode, pse_frame_ctrl.
//
// Usage: raw plot command bytes arrive on in_i, one request per byte, and the
// bytes of the selected frame leave on out_o, unchanged and in order. Command
// letters are decoded to skip their argument bytes; erase commands advance the
// frame counter and are never passed on; unknown commands are dropped. Once a
// frame after the selected one begins, every further byte is dropped.
// wanted_frame_i is loaded when wanted_frame_we_i is high; write it only while
// the block is idle.
// A byte accepted into the input register is decoded combinationally from it
// and, if passed, is loaded into the result register that drives out_o.
// Throughput: one byte per cycle while out_o is not held off, set by the
// combinational decode and counter update between the input register and
// the result register.
// Stalls: when out_o is held off, the result register holds and the input
// register fills; in_i.ready drops only when both are occupied.
// Reset: clears both registers' valid flags, the frame counter, the finished flag,
// the argument and label tracking and the wanted frame register (frame 0).
module plot_stream_frame_extractor import pse_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pse_in_if.sink              in_i,
  pse_out_if.source           out_o,
  input  logic                wanted_frame_we_i,
  input  logic [WANTED_W-1:0] wanted_frame_i
);

  logic [WANTED_W-1:0] wanted_frame_q;
  logic                in_valid_q;
  logic [BYTE_W-1:0]   in_byte_q;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                step;
  logic                emit;
  cmd_dec_t            dec;

  // Consume the held byte when the result slot is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_frame_q <= '0;
    end else if (wanted_frame_we_i) begin
      wanted_frame_q <= wanted_frame_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  pse_cmd_decode u_decode (
    .byte_i (in_byte_q),
    .dec_o  (dec)
  );

  pse_frame_ctrl #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_i         (in_byte_q),
    .dec_i          (dec),
    .wanted_frame_i (wanted_frame_q),
    .emit_o         (emit)
  );

  // Result register: load on a passed byte, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_byte_q <= in_byte_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule

[dv/plot_stream_frame_extractor_tb.sv]
// Self-checking testbench for the plot stream frame extractor.
// Predicts passed bytes with its own command parser and compares them on out_o.
// Depends on pse_pkg, pse_in_if, pse_out_if and plot_stream_frame_extractor.
module plot_stream_frame_extractor_tb import pse_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CALM_LO    = 2000;
  localparam int unsigned CALM_HI    = 6000;
  localparam int unsigned DRAIN_CYC  = 4;
  localparam int unsigned MAX_PRINTS = 20;
  localparam longint      TIMEOUT_NS = 64'd6_000_000;

  // Narrow frame counter so that its top value is reached in a short run
  localparam int unsigned         TB_FRAME_BITS = 8;
  localparam logic [WANTED_W-1:0] TOP_FRAME     = WANTED_W'((1 << TB_FRAME_BITS) - 1);

  // Opening stream at frame 0: unknown bytes at the table edges, a command
  // without arguments, colour and short arguments holding command-like
  // bytes, and two labels, one of them empty
  localparam logic [7:0] OPENING [23] = '{
    8'h00, 8'hFF, 8'h40, 8'h7B, "[", "A", "z", "F",
    "C", 8'h00, 8'hFF, "e",
    "t", "e", 8'hFF, LF_CODE,
    "f", LF_CODE,
    "m", "V", LF_CODE, 8'h80, 8'h7F
  };

  logic clk_i;
  logic rst_ni;
  logic                wanted_we;
  logic [WANTED_W-1:0] wanted_data;

  pse_in_if  in_if ();
  pse_out_if out_if ();

  plot_stream_frame_extractor #(
    .FRAME_BITS (TB_FRAME_BITS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_if),
    .out_o             (out_if),
    .wanted_frame_we_i (wanted_we),
    .wanted_frame_i    (wanted_data)
  );

  // Parser state mirrored from the block
  logic [WANTED_W-1:0]      sel_frame;
  logic [TB_FRAME_BITS-1:0] frame_cnt;
  bit                       frame_done;
  logic [ARG_W-1:0]         skip_left;
  bit                       label_open;
  bit                       finish_ok;

  logic [7:0] byte_stream_q [$];
  logic [7:0] passed_bytes_q [$];

  string       cmd_letters = "CFLMNOPQSVWXacfilmnopqrstvwx";
  int unsigned cyc;
  int unsigned sent;
  int unsigned accepted;
  int unsigned passed;
  int unsigned err_cnt;
  bit          in_took;
  logic [7:0]  want_b;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Command letter table: class and fixed argument length
  function automatic cmd_kind_e letter_class(input logic [7:0] b, output logic [ARG_W-1:0] len);
    cmd_kind_e kind;
    kind = CMD_ARG;
    len  = '0;
    case (b)
      "C":           len  = 6'd3;
      "F":           len  = 6'd0;
      "L", "S", "a": len  = 6'd12;
      "M", "N", "P", "c": len = 6'd6;
      "O", "Q", "X", "i": len = 6'd24;
      "V", "W", "r": len  = 6'd48;
      "l", "s":      len  = 6'd8;
      "m", "n", "p": len  = 6'd4;
      "o", "q", "x": len  = 6'd16;
      "v", "w":      len  = 6'd32;
      "e":           kind = CMD_ERASE;
      "f", "t":      kind = CMD_LABEL;
      default:       kind = CMD_BAD;
    endcase
    return kind;
  endfunction

  // Advance the parser by one byte; return 1 when the byte is passed on
  function automatic bit parse_byte(input logic [7:0] b);
    cmd_kind_e        kind;
    logic [ARG_W-1:0] len;
    logic [16:0]      nxt;
    if (frame_done) return 1'b0;
    if (label_open) begin
      if (b == LF_CODE) label_open = 1'b0;
      return WANTED_W'(frame_cnt) == sel_frame;
    end
    if (skip_left != '0) begin
      skip_left = skip_left - 6'd1;
      return WANTED_W'(frame_cnt) == sel_frame;
    end
    kind = letter_class(b, len);
    case (kind)
      CMD_BAD: return 1'b0;
      CMD_ERASE: begin
        nxt = 17'(frame_cnt) + 17'd1;
        if (nxt > 17'(sel_frame)) frame_done = 1'b1;
        if (frame_cnt != '1) frame_cnt = frame_cnt + TB_FRAME_BITS'(1);
        return 1'b0;
      end
      CMD_LABEL: label_open = 1'b1;
      default: skip_left = len;
    endcase
    return WANTED_W'(frame_cnt) == sel_frame;
  endfunction

  // Queue one byte and its prediction; swap an erase that would end the run
  // for a plain command unless ending is allowed
  task automatic send_byte(input logic [7:0] b);
    logic [ARG_W-1:0] len;
    logic [7:0]       v;
    v = b;
    if (!finish_ok && !frame_done && !label_open && skip_left == '0 &&
        letter_class(v, len) == CMD_ERASE && (17'(frame_cnt) + 17'd1) > 17'(sel_frame))
      v = "F";
    if (parse_byte(v)) passed_bytes_q.push_back(v);
    byte_stream_q.push_back(v);
    sent++;
  endtask

  // Argument byte, biased towards bytes that look like commands
  function automatic logic [7:0] pick_arg();
    case ($urandom_range(7))
      0:       return "e";
      1:       return LF_CODE;
      2:       return cmd_letters[$urandom_range(cmd_letters.len() - 1)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed commands with random arguments, some noise and
  // truncated commands
  task automatic stream_random(input int unsigned n);
    int unsigned      stop_at;
    int unsigned      r;
    int unsigned      cnt;
    logic [7:0]       letter;
    logic [7:0]       a;
    logic [ARG_W-1:0] len;
    cmd_kind_e        kind;
    stop_at = sent + n;
    while (sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_byte(8'($urandom_range(255)));
      end else if (r < 35 && WANTED_W'(frame_cnt) < sel_frame) begin
        send_byte("e");
      end else begin
        letter = cmd_letters[$urandom_range(cmd_letters.len() - 1)];
        kind   = letter_class(letter, len);
        send_byte(letter);
        if (kind == CMD_LABEL) begin
          cnt = $urandom_range(6);
          repeat (cnt) begin
            a = pick_arg();
            if (a == LF_CODE) a = 8'h0B;
            send_byte(a);
          end
          if ($urandom_range(19) != 0) send_byte(LF_CODE);
        end else begin
          cnt = 32'(len);
          if ($urandom_range(9) == 0) cnt = $urandom_range(32'(len));
          repeat (cnt) send_byte(pick_arg());
        end
      end
    end
  endtask

  // Wait until every byte is taken and every result has arrived
  task automatic settle();
    while (byte_stream_q.size() != 0 || passed_bytes_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic load_wanted(input logic [WANTED_W-1:0] v);
    @(negedge clk_i);
    wanted_we   <= 1'b1;
    wanted_data <= v;
    @(negedge clk_i);
    wanted_we   <= 1'b0;
    sel_frame = v;
  endtask

  task automatic note_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit idle_now();
    return (cyc < CALM_LO || cyc > CALM_HI) && ($urandom_range(99) < 33);
  endfunction

  // Drive requests: hold an unaccepted request, else offer the next byte
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_took)) begin
      if (byte_stream_q.size() != 0 && !idle_now()) begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= byte_stream_q[0];
      end else begin
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'($urandom_range(255));
      end
    end
    out_if.ready <= rst_ni && !idle_now();
  end

  // Sample both channels and check passed bytes in order
  always @(posedge clk_i) begin
    cyc     <= cyc + 1;
    in_took <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      void'(byte_stream_q.pop_front());
      accepted++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (passed_bytes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected out_byte %02h", out_if.out_byte));
      end else begin
        want_b = passed_bytes_q.pop_front();
        if (out_if.out_byte !== want_b)
          note_mismatch($sformatf("out_byte %02h, wanted %02h", out_if.out_byte, want_b));
        passed++;
      end
    end
  end

  // Stimulus phases
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    wanted_we     = 1'b0;
    wanted_data   = '0;
    sel_frame     = '0;
    frame_cnt     = '0;
    frame_done    = 1'b0;
    skip_left     = '0;
    label_open    = 1'b0;
    finish_ok     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Frame 0 selected, opening stream
    load_wanted('0);
    foreach (OPENING[i]) send_byte(OPENING[i]);
    settle();

    // Skip early frames, pass a later one
    load_wanted(16'd5);
    stream_random(400);
    settle();

    load_wanted(16'd12);
    stream_random(330);
    settle();

    // Selected frame already behind: drop everything but keep parsing
    load_wanted(16'd7);
    stream_random(60);
    settle();

    // Top frame: erase up to it, pass it, then end the frame
    load_wanted(TOP_FRAME);
    while (frame_cnt != '1) send_byte(label_open ? LF_CODE : 8'("e"));
    stream_random(550);
    finish_ok = 1'b1;
    while (!frame_done) send_byte(label_open ? LF_CODE : 8'("e"));
    stream_random(40);
    settle();

    repeat (10) @(negedge clk_i);
    $display("Summary: %0d bytes accepted across %0d frame counts, %0d passed, %0d mismatches",
             accepted, frame_cnt, passed, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d bytes left to send, %0d results outstanding",
             byte_stream_q.size(), passed_bytes_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
